// ----- hw/rtl/wsd_pkg.sv -----
// Shared types and constants for the WebSocket receive deframer.
`default_nettype none

package wsd_pkg;

  // Header parse phase, one-hot.
  typedef enum logic [4:0] {
    PH_OPCODE  = 5'b00001,
    PH_LENGTH  = 5'b00010,
    PH_EXT     = 5'b00100,
    PH_KEY     = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_e;

  // Result kinds.
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // Opcode types: continuation, and close and pong whose payload is consumed without output.
  localparam logic [3:0] OP_TYPE_CONT  = 4'h0;
  localparam logic [3:0] OP_TYPE_CLOSE = 4'h8;
  localparam logic [3:0] OP_TYPE_PONG  = 4'hA;

  // Length byte decoding.
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [2:0] EXT16_LAST_CNT = 3'd1;
  localparam logic [2:0] EXT64_LAST_CNT = 3'd7;
  localparam logic [2:0] KEY_LAST_IDX   = 3'd3;

  // One result word.
  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [3:0]  message_type;
    logic        final_fragment;
    logic [62:0] frame_length;
    logic        last_of_frame;
    logic        close_seen;
  } result_t;

  // Parser status seen by the top level.
  typedef struct packed {
    phase_e phase;
    logic   rem_zero;
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wsd_in_stage.sv -----
// Input register stage holding one received byte.
`default_nettype none

module wsd_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_valid_i,
  output logic            s_ready_o,
  input  wire logic [7:0] s_data_i,
  input  wire logic       consume_i,
  output logic            valid_o,
  output logic [7:0]      data_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;

  // The register frees when empty or when its word moves on this cycle.
  assign s_ready_o = !valid_q || consume_i;
  assign valid_d   = s_ready_o ? s_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      data_q <= s_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ----- hw/rtl/wsd_parser.sv -----
// Frame header parser and payload unmasking with its state registers.
`default_nettype none

module wsd_parser (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       advance_i,
  input  wire logic [7:0] byte_i,
  output logic            emit_o,
  output wsd_pkg::result_t result_o,
  output wsd_pkg::status_t status_o
);

  wsd_pkg::phase_e state_q, state_d;
  logic [7:0]       kept_q, kept_d;
  logic             mask_q, mask_d;
  logic [63:0]      rem_q, rem_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [1:0]       pos_q, pos_d;
  logic [3:0][7:0]  key_q, key_d;

  logic       finish;
  logic       emit_pay;
  logic       pay_last;
  logic [7:0] pay_byte;
  logic       dropped;
  logic       is_close;
  logic       empty;

  assign dropped  = (kept_q[3:0] == wsd_pkg::OP_TYPE_CLOSE) ||
                    (kept_q[3:0] == wsd_pkg::OP_TYPE_PONG);
  assign is_close = (kept_q[3:0] == wsd_pkg::OP_TYPE_CLOSE);

  // Next-state logic for one byte.
  always_comb begin
    state_d  = state_q;
    kept_d   = kept_q;
    mask_d   = mask_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    key_d    = key_q;
    finish   = 1'b0;
    emit_pay = 1'b0;
    pay_last = 1'b0;
    pay_byte = byte_i;
    case (state_q)
      wsd_pkg::PH_OPCODE: begin
        // A continuation opcode merges its flags into the kept opcode.
        if (byte_i[3:0] == wsd_pkg::OP_TYPE_CONT) begin
          kept_d = kept_q | byte_i;
        end else begin
          kept_d = byte_i;
        end
        state_d = wsd_pkg::PH_LENGTH;
      end
      wsd_pkg::PH_LENGTH: begin
        mask_d = byte_i[7];
        rem_d  = '0;
        if (byte_i[6:0] < wsd_pkg::LEN_CODE_EXT16) begin
          rem_d = {57'd0, byte_i[6:0]};
          if (byte_i[7]) begin
            state_d = wsd_pkg::PH_KEY;
            cnt_d   = '0;
          end else begin
            finish = 1'b1;
          end
        end else begin
          state_d = wsd_pkg::PH_EXT;
          cnt_d   = (byte_i[6:0] == wsd_pkg::LEN_CODE_EXT16) ?
                    wsd_pkg::EXT16_LAST_CNT : wsd_pkg::EXT64_LAST_CNT;
        end
      end
      wsd_pkg::PH_EXT: begin
        // Extended length arrives most significant byte first.
        rem_d = {rem_q[55:0], byte_i};
        if (cnt_q == '0) begin
          if (mask_q) begin
            state_d = wsd_pkg::PH_KEY;
          end else begin
            finish = 1'b1;
          end
        end else begin
          cnt_d = cnt_q - 3'd1;
        end
      end
      wsd_pkg::PH_KEY: begin
        key_d[cnt_q[1:0]] = byte_i;
        if (cnt_q == wsd_pkg::KEY_LAST_IDX) begin
          finish = 1'b1;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      wsd_pkg::PH_PAYLOAD: begin
        // Unmask by cycling through the key.
        if (mask_q) begin
          pay_byte = byte_i ^ key_q[pos_q];
          pos_d    = pos_q + 2'd1;
        end
        rem_d    = rem_q - 64'd1;
        pay_last = (rem_q == 64'd1);
        if (pay_last) begin
          state_d = wsd_pkg::PH_OPCODE;
        end
        emit_pay = !dropped;
      end
      default: begin
        state_d = wsd_pkg::PH_OPCODE;
      end
    endcase
    // Header complete: report it and head for the payload or the next frame.
    if (finish) begin
      pos_d   = '0;
      state_d = (rem_d == 64'd0) ? wsd_pkg::PH_OPCODE : wsd_pkg::PH_PAYLOAD;
    end
  end

  assign empty = (rem_d == 64'd0);

  // Result word assembly.
  always_comb begin
    result_o.message_type   = kept_q[3:0];
    result_o.final_fragment = kept_q[7];
    if (finish) begin
      result_o.result_kind   = wsd_pkg::KIND_HEADER;
      result_o.payload_byte  = '0;
      result_o.frame_length  = rem_d[62:0];
      result_o.last_of_frame = empty || dropped;
      result_o.close_seen    = is_close;
    end else begin
      result_o.result_kind   = wsd_pkg::KIND_PAYLOAD;
      result_o.payload_byte  = pay_byte;
      result_o.frame_length  = '0;
      result_o.last_of_frame = pay_last;
      result_o.close_seen    = 1'b0;
    end
  end

  assign emit_o = finish || emit_pay;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wsd_pkg::PH_OPCODE;
      kept_q  <= '0;
      mask_q  <= 1'b0;
      rem_q   <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
      key_q   <= '0;
    end else if (advance_i) begin
      state_q <= state_d;
      kept_q  <= kept_d;
      mask_q  <= mask_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      key_q   <= key_d;
    end
  end

  assign status_o.phase    = state_q;
  assign status_o.rem_zero = (rem_q == 64'd0);

endmodule

`default_nettype wire

// ----- hw/rtl/wsd_out_stage.sv -----
// Output register holding one result word for the downstream side.
`default_nettype none

module wsd_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire wsd_pkg::result_t result_i,
  output logic                  can_load_o,
  input  wire logic             m_ready_i,
  output logic                  m_valid_o,
  output wsd_pkg::result_t      m_result_o
);

  logic             valid_q, valid_d;
  wsd_pkg::result_t result_q;

  // A new word may enter when empty or when the held word is taken.
  assign can_load_o = !valid_q || m_ready_i;
  assign valid_d    = load_i ? 1'b1 : (m_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign m_valid_o  = valid_q;
  assign m_result_o = result_q;

endmodule

`default_nettype wire

// ----- hw/rtl/websocket_frame_receive_deframer_core.sv -----
// Top level of the WebSocket receive deframer.
//
// Usage: received connection bytes enter on the s_axis channel, one byte per
// word in tdata. The block parses the frame header (opcode, mask bit and
// length, optional 16- or 64-bit extended length, optional 4-byte key) and
// then emits one header word followed by the unmasked payload bytes on the
// m_axis channel. tuser carries the result kind (0 header, 1 payload byte)
// and tlast marks the final word of a frame. Close and pong payloads are
// consumed without output; ping and data payloads are passed on.
// A byte is first held in the input register for its parse step, and its
// result is then loaded into the result register. Throughput: one byte
// per cycle while the receiver does not stall, set by the single parse step
// between the two registers.
// Reset clears the parser to expect an opcode byte and empties both
// registers. When the receiver stalls, the result register holds its word
// and bytes that give no result keep flowing; a byte that gives a result
// waits in the input register, and tready drops once that is full.
`default_nettype none

module websocket_frame_receive_deframer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // [7:0] rx_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] payload_byte, [11:8] message_type, [12] final_fragment,
  // [75:13] frame_length, [76] close_seen, [79:77] zero
  output logic [79:0]      m_axis_tdata_o,
  output logic             m_axis_tlast_o,  // last_of_frame
  output logic             m_axis_tuser_o   // [0] result_kind
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             advance;
  logic             emit;
  logic             can_load;
  wsd_pkg::result_t result;
  wsd_pkg::result_t out_result;
  wsd_pkg::status_t status;

  // A byte moves on unless it makes a result that has nowhere to go.
  assign advance = in_valid && (!emit || can_load);

  wsd_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_data_i  (s_axis_tdata_i),
    .consume_i (advance),
    .valid_o   (in_valid),
    .data_o    (in_byte)
  );

  wsd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (in_byte),
    .emit_o    (emit),
    .result_o  (result),
    .status_o  (status)
  );

  wsd_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && emit),
    .result_i   (result),
    .can_load_o (can_load),
    .m_ready_i  (m_axis_tready_i),
    .m_valid_o  (m_axis_tvalid_o),
    .m_result_o (out_result)
  );

  // Output word packing.
  assign m_axis_tdata_o = {3'b000, out_result.close_seen, out_result.frame_length,
                           out_result.final_fragment, out_result.message_type,
                           out_result.payload_byte};
  assign m_axis_tlast_o = out_result.last_of_frame;
  assign m_axis_tuser_o = out_result.result_kind;

  // The payload phase always has bytes left to take.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.phase == wsd_pkg::PH_PAYLOAD |-> !status.rem_zero)
    else $error("payload phase entered with zero remaining length");

  // A payload word carries no length and no close flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[76:13] == '0)
    else $error("payload word with header fields set");

  // Close flag only on close frames.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[76] |->
      m_axis_tdata_o[11:8] == wsd_pkg::OP_TYPE_CLOSE)
    else $error("close flag on a non-close frame");

  // A held input byte that cannot move stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !advance |=> in_valid && $stable(in_byte))
    else $error("stalled input byte lost");

endmodule

`default_nettype wire
